/* src/ezrc_pkg.sv */
// Shared types and constants of the escaped zero-run codec.
package ezrc_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'hEE;
   localparam logic [7:0] MIN_RUN    = 8'd2;
   localparam int         MAX_WORDS  = 4;
   localparam int         WORD_IW    = 2;
   localparam int         WORD_CW    = 3;
   localparam int         QUEUE_AW   = 2;
   localparam int         QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic DIR_COMPRESS   = 1'b0;
   localparam logic DIR_DECOMPRESS = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } ezrc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] repeat_count;
      logic       last_out;
   } ezrc_rsp_type;

   typedef struct packed {
      logic [WORD_IW-1:0]                last_idx;
      ezrc_rsp_type [MAX_WORDS-1:0]      words;
   } ezrc_cmd_type;

endpackage

/* src/escaped_zero_run_codec_top.sv */
// Top level of the escaped zero-run byte codec.
// The req channel takes one stream byte per word with a final-byte flag, and the rsp
// channel returns output bytes with a repeat count and a final-word flag. Both use
// valid and ready. The csr channel writes the direction bit (0 compresses, 1
// decompresses); it is always ready, and a write also clears the held zero run and
// the pending escape, starting a new stream. Write it only while the block is idle.
// A byte is accepted every cycle while the command queue has room. Each accepted
// byte yields zero to four result words; its first word goes to rsp via the command
// queue and the output register. The back end sends one result word per cycle while
// the receiver is ready, so a byte with several words keeps it busy word by word and
// the four-entry queue absorbs the burst. When the receiver stalls, the output
// register holds its word, the queue fills and req_ready falls once it is full.
// Reset clears the direction to compress, the codec state and the queue.
module escaped_zero_run_codec_top #(
   parameter int MAX_RUN = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ezrc_pkg::ezrc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ezrc_pkg::ezrc_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata
);
   import ezrc_pkg::*;

   logic         queue_full;
   logic         push_valid;
   ezrc_cmd_type push_cmd;
   logic         head_valid;
   ezrc_cmd_type head_cmd;
   logic         pop;

   assign csr_ready = 1'b1;

   ezrc_front #(
      .MAX_RUN(MAX_RUN)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_wdata(csr_wdata),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_cmd(push_cmd)
   );

   ezrc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_cmd(push_cmd),
      .full(queue_full),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .pop(pop)
   );

   ezrc_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

/* src/ezrc_front.sv */
// Front end: accepts input words, tracks codec state and builds result commands.
module ezrc_front #(
   parameter int MAX_RUN = 255
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ezrc_pkg::ezrc_req_type req_data,
   input  logic                  csr_valid,
   input  logic                  csr_wdata,
   input  logic                  queue_full,
   output logic                  push_valid,
   output ezrc_pkg::ezrc_cmd_type push_cmd
);
   import ezrc_pkg::*;

   localparam logic [7:0] MaxRunB = 8'(MAX_RUN);

   logic                        dir_ff, dir_in;
   logic [7:0]                  zero_run_ff, zero_run_in;
   logic                        esc_ff, esc_in;
   ezrc_rsp_type [MAX_WORDS-1:0] words;
   logic [WORD_CW-1:0]          n;
   logic                        do_flush;
   logic [7:0]                  flush_val;
   logic [7:0]                  b;
   logic                        last;
   logic                        accept;

   assign b         = req_data.in_byte;
   assign last      = req_data.last_in;
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      words       = '0;
      n           = '0;
      zero_run_in = zero_run_ff;
      esc_in      = esc_ff;
      do_flush    = 1'b0;
      flush_val   = '0;
      if (dir_ff == DIR_COMPRESS) begin
         if (b == 8'd0) begin
            zero_run_in = zero_run_ff + 8'd1;
            if (zero_run_in >= MaxRunB || last) begin
               do_flush    = 1'b1;
               flush_val   = zero_run_in;
               zero_run_in = '0;
            end
         end else begin
            do_flush    = 1'b1;
            flush_val   = zero_run_ff;
            zero_run_in = '0;
         end
         if (do_flush) begin
            if (flush_val == 8'd1) begin
               words[n[WORD_IW-1:0]] = '{out_byte: 8'd0, repeat_count: 8'd1, last_out: 1'b0};
               n = n + 3'd1;
            end else if (flush_val >= MIN_RUN) begin
               words[n[WORD_IW-1:0]] = '{out_byte: ESC_BYTE, repeat_count: 8'd1, last_out: 1'b0};
               n = n + 3'd1;
               words[n[WORD_IW-1:0]] = '{out_byte: flush_val, repeat_count: 8'd1, last_out: 1'b0};
               n = n + 3'd1;
            end
         end
         if (b == ESC_BYTE) begin
            words[n[WORD_IW-1:0]] = '{out_byte: ESC_BYTE, repeat_count: 8'd1, last_out: 1'b0};
            n = n + 3'd1;
            words[n[WORD_IW-1:0]] = '{out_byte: 8'd0, repeat_count: 8'd1, last_out: 1'b0};
            n = n + 3'd1;
         end else if (b != 8'd0) begin
            words[n[WORD_IW-1:0]] = '{out_byte: b, repeat_count: 8'd1, last_out: 1'b0};
            n = n + 3'd1;
         end
      end else begin
         if (esc_ff) begin
            esc_in = 1'b0;
            if (b >= MIN_RUN) begin
               words[0] = '{out_byte: 8'd0, repeat_count: b, last_out: 1'b0};
            end else begin
               words[0] = '{out_byte: ESC_BYTE, repeat_count: 8'd1, last_out: 1'b0};
            end
            n = 3'd1;
         end else if (b == ESC_BYTE) begin
            if (last) begin
               words[0] = '{out_byte: ESC_BYTE, repeat_count: 8'd1, last_out: 1'b0};
               n = 3'd1;
            end else begin
               esc_in = 1'b1;
            end
         end else begin
            words[0] = '{out_byte: b, repeat_count: 8'd1, last_out: 1'b0};
            n = 3'd1;
         end
      end
      if (last) begin
         zero_run_in = '0;
         esc_in      = 1'b0;
         if (n != '0) begin
            words[WORD_IW'(n - 3'd1)].last_out = 1'b1;
         end
      end
   end

   assign push_valid        = accept && (n != '0);
   assign push_cmd.words    = words;
   assign push_cmd.last_idx = WORD_IW'(n - 3'd1);

   assign dir_in = csr_valid ? csr_wdata : dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff      <= DIR_COMPRESS;
         zero_run_ff <= '0;
         esc_ff      <= 1'b0;
      end else begin
         dir_ff <= dir_in;
         if (csr_valid) begin
            zero_run_ff <= '0;
            esc_ff      <= 1'b0;
         end else if (accept) begin
            zero_run_ff <= zero_run_in;
            esc_ff      <= esc_in;
         end
      end
   end

endmodule

/* src/ezrc_queue.sv */
// Short command queue between the front end and the back end.
module ezrc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  ezrc_pkg::ezrc_cmd_type push_cmd,
   output logic                   full,
   output logic                   head_valid,
   output ezrc_pkg::ezrc_cmd_type head_cmd,
   input  logic                   pop
);
   import ezrc_pkg::*;

   ezrc_cmd_type             entries [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]        count_ff, count_in;
   logic                     do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

/* src/ezrc_back.sv */
// Back end: sends the words of each queued command one at a time through the output register.
module ezrc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  ezrc_pkg::ezrc_cmd_type head_cmd,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ezrc_pkg::ezrc_rsp_type rsp_data
);
   import ezrc_pkg::*;

   logic [WORD_IW-1:0] idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ezrc_rsp_type       rsp_data_ff, rsp_data_in;
   logic               load;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && (idx_ff == head_cmd.last_idx);

   always_comb begin
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_data_in  = head_cmd.words[idx_ff];
         rsp_valid_in = 1'b1;
         idx_in       = pop ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
